>>> src/fcs_pkg.sv
// shared types, constants and lookup for the filled-circle span generator
`default_nettype none

package fcs_pkg;

  // field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned ColourW = 16;
  localparam int unsigned RadiusW = 4;
  localparam int unsigned LenW    = 5;
  localparam int unsigned LimitW  = 8;   // r*r + r/2 for a 4-bit radius
  localparam int unsigned SumW    = 9;   // i*i + x*x for 4-bit i and x
  localparam int unsigned RadiusTop = (1 << RadiusW) - 1;

  // one circle command
  typedef struct packed {
    logic [CoordW-1:0]  centre_x;
    logic [CoordW-1:0]  centre_y;
    logic [RadiusW-1:0] radius;
    logic [ColourW-1:0] fill_colour;
  } cmd_t;

  // one emitted span
  typedef struct packed {
    logic [CoordW-1:0]  span_x;
    logic [CoordW-1:0]  span_y;
    logic [LenW-1:0]    span_length;
    logic [ColourW-1:0] span_colour;
    logic               last_span;
  } span_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CENTRE,
    ST_TEST,
    ST_OUTER_P,
    ST_OUTER_N,
    ST_INNER_P,
    ST_INNER_N,
    ST_FLUSH
  } ctrl_state_e;

  // operands and requests from the sequencer to the span unit and output stage
  typedef struct packed {
    logic               emit;     // a candidate span is presented
    logic               flush;    // release the held span as the last one
    logic [RadiusW-1:0] col_off;  // subtracted from the centre column
    logic [RadiusW-1:0] row_off;  // added to or subtracted from the centre row
    logic               row_neg;
    logic [RadiusW-1:0] half_len; // span length is twice this
  } ctrl_t;

  // step count r*707/1000 + 1 for every 4-bit radius
  function automatic logic [RadiusW-1:0] imax_lut(input logic [RadiusW-1:0] r);
    logic [RadiusW-1:0] v;
    unique case (r)
      4'd0:    v = 4'd1;
      4'd1:    v = 4'd1;
      4'd2:    v = 4'd2;
      4'd3:    v = 4'd3;
      4'd4:    v = 4'd3;
      4'd5:    v = 4'd4;
      4'd6:    v = 4'd5;
      4'd7:    v = 4'd5;
      4'd8:    v = 4'd6;
      4'd9:    v = 4'd7;
      4'd10:   v = 4'd8;
      4'd11:   v = 4'd8;
      4'd12:   v = 4'd9;
      4'd13:   v = 4'd10;
      4'd14:   v = 4'd10;
      default: v = 4'd11;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/fcs_span_unit.sv
// shared span arithmetic: column, row and length from centre and offsets
`default_nettype none

module fcs_span_unit (
  input  var fcs_pkg::cmd_t  cmd_i,
  input  var fcs_pkg::ctrl_t ctrl_i,
  output fcs_pkg::span_t     span_o
);

  logic [fcs_pkg::CoordW-1:0] col_ext;
  logic [fcs_pkg::CoordW-1:0] row_ext;

  assign col_ext = fcs_pkg::CoordW'(ctrl_i.col_off);
  assign row_ext = fcs_pkg::CoordW'(ctrl_i.row_off);

  // wrapping coordinate arithmetic, length doubled from half width
  always_comb begin
    span_o.span_x      = cmd_i.centre_x - col_ext;
    span_o.span_y      = ctrl_i.row_neg ? (cmd_i.centre_y - row_ext)
                                        : (cmd_i.centre_y + row_ext);
    span_o.span_length = {ctrl_i.half_len, 1'b0};
    span_o.span_colour = cmd_i.fill_colour;
    span_o.last_span   = 1'b0;
  end

endmodule

`default_nettype wire

>>> src/fcs_ctrl.sv
// span sequencer: step counter, column tracker and ring test
`default_nettype none

module fcs_ctrl #(
  parameter int unsigned MAX_RADIUS = 15
) (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          cmd_valid_i,
  input  var fcs_pkg::cmd_t cmd_i,
  input  var logic          adv_i,
  output logic              busy_o,
  output fcs_pkg::cmd_t     cmd_o,
  output fcs_pkg::ctrl_t    ctrl_o
);

  localparam int unsigned RCap =
    (MAX_RADIUS > fcs_pkg::RadiusTop) ? fcs_pkg::RadiusTop : MAX_RADIUS;

  fcs_pkg::ctrl_state_e state_q, state_d;
  fcs_pkg::cmd_t        cmd_q, cmd_d;
  logic [fcs_pkg::RadiusW-1:0] x_q, x_d;
  logic [fcs_pkg::RadiusW-1:0] i_q, i_d;
  logic [fcs_pkg::RadiusW-1:0] imax_q, imax_d;
  logic [fcs_pkg::LimitW-1:0]  limit_q, limit_d;
  logic [fcs_pkg::RadiusW-1:0] rad_sat;
  logic [fcs_pkg::RadiusW-1:0] r_q;
  logic [fcs_pkg::SumW-1:0]    sq_sum;
  logic                        outside;

  assign r_q = cmd_q.radius;

  // radius clamp on the incoming command
  assign rad_sat = (cmd_i.radius > fcs_pkg::RadiusW'(RCap)) ? fcs_pkg::RadiusW'(RCap)
                                                          : cmd_i.radius;

  // ring test: i*i + x*x against the stored limit
  assign sq_sum  = fcs_pkg::SumW'(i_q) * fcs_pkg::SumW'(i_q)
                 + fcs_pkg::SumW'(x_q) * fcs_pkg::SumW'(x_q);
  assign outside = sq_sum > fcs_pkg::SumW'(limit_q);

  assign busy_o = (state_q != fcs_pkg::ST_IDLE);
  assign cmd_o  = cmd_q;

  // next state, loop registers and span operands
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    x_d     = x_q;
    i_d     = i_q;
    imax_d  = imax_q;
    limit_d = limit_q;
    ctrl_o  = '0;
    unique case (state_q)
      fcs_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d        = cmd_i;
          cmd_d.radius = rad_sat;
          if (rad_sat != '0) begin
            state_d = fcs_pkg::ST_SETUP;
          end
        end
      end
      fcs_pkg::ST_SETUP: begin
        limit_d = fcs_pkg::LimitW'(r_q) * fcs_pkg::LimitW'(r_q)
                + fcs_pkg::LimitW'(r_q >> 1);
        imax_d  = fcs_pkg::imax_lut(r_q);
        x_d     = r_q;
        i_d     = fcs_pkg::RadiusW'(1);
        state_d = fcs_pkg::ST_CENTRE;
      end
      fcs_pkg::ST_CENTRE: begin
        ctrl_o.emit     = 1'b1;
        ctrl_o.col_off  = r_q;
        ctrl_o.half_len = r_q;
        if (adv_i) begin
          state_d = fcs_pkg::ST_TEST;
        end
      end
      fcs_pkg::ST_TEST: begin
        if (outside && (x_q > imax_q)) begin
          state_d = fcs_pkg::ST_OUTER_P;
        end else begin
          if (outside && (x_q != '0)) begin
            x_d = x_q - fcs_pkg::RadiusW'(1);
          end
          state_d = fcs_pkg::ST_INNER_P;
        end
      end
      fcs_pkg::ST_OUTER_P, fcs_pkg::ST_OUTER_N: begin
        ctrl_o.emit     = 1'b1;
        ctrl_o.col_off  = i_q - fcs_pkg::RadiusW'(1);
        ctrl_o.row_off  = x_q;
        ctrl_o.row_neg  = (state_q == fcs_pkg::ST_OUTER_N);
        ctrl_o.half_len = i_q - fcs_pkg::RadiusW'(1);
        if (adv_i) begin
          if (state_q == fcs_pkg::ST_OUTER_P) begin
            state_d = fcs_pkg::ST_OUTER_N;
          end else begin
            x_d     = x_q - fcs_pkg::RadiusW'(1);
            state_d = fcs_pkg::ST_INNER_P;
          end
        end
      end
      fcs_pkg::ST_INNER_P, fcs_pkg::ST_INNER_N: begin
        ctrl_o.emit     = 1'b1;
        ctrl_o.col_off  = x_q;
        ctrl_o.row_off  = i_q;
        ctrl_o.row_neg  = (state_q == fcs_pkg::ST_INNER_N);
        ctrl_o.half_len = x_q;
        if (adv_i) begin
          if (state_q == fcs_pkg::ST_INNER_P) begin
            state_d = fcs_pkg::ST_INNER_N;
          end else begin
            i_d     = i_q + fcs_pkg::RadiusW'(1);
            state_d = (i_q == imax_q) ? fcs_pkg::ST_FLUSH : fcs_pkg::ST_TEST;
          end
        end
      end
      fcs_pkg::ST_FLUSH: begin
        ctrl_o.flush = 1'b1;
        if (adv_i) begin
          state_d = fcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fcs_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command and loop registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    x_q     <= x_d;
    i_q     <= i_d;
    imax_q  <= imax_d;
    limit_q <= limit_d;
  end

endmodule

`default_nettype wire

>>> src/fcs_out_stage.sv
// one-span hold register plus output register, marks the final span
`default_nettype none

module fcs_out_stage (
  input  var logic           clk_i,
  input  var logic           rst_ni,
  input  var fcs_pkg::ctrl_t ctrl_i,
  input  var fcs_pkg::span_t cand_i,
  output logic               adv_o,
  output logic               out_valid_o,
  input  var logic           out_stall_i,
  output fcs_pkg::span_t     out_data_o
);

  logic           pend_valid_q, pend_valid_d;
  fcs_pkg::span_t pend_q, pend_d;
  logic           out_valid_q, out_valid_d;
  fcs_pkg::span_t out_q, out_d;
  logic           slot_free;
  logic           cand_zero;
  logic           load_out;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign cand_zero = (cand_i.span_length == '0);

  // a held span moves on only when the output register can take it
  always_comb begin
    adv_o        = 1'b0;
    load_out     = 1'b0;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_d        = out_q;
    if (ctrl_i.emit) begin
      adv_o = cand_zero || !pend_valid_q || slot_free;
      if (!cand_zero && adv_o) begin
        if (pend_valid_q) begin
          load_out = 1'b1;
          out_d    = pend_q;
        end
        pend_valid_d = 1'b1;
        pend_d       = cand_i;
      end
    end else if (ctrl_i.flush) begin
      adv_o = !pend_valid_q || slot_free;
      if (pend_valid_q && slot_free) begin
        load_out           = 1'b1;
        out_d              = pend_q;
        out_d.last_span    = 1'b1;
        pend_valid_d       = 1'b0;
      end
    end
    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // span payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> src/filled_circle_span_generator_core.sv
// filled-circle span generator top level: sequencer, span unit, output stage
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------
//   in      | input     | in_valid_i/in_stall_o   | fcs_pkg::cmd_t command
//   out     | output    | out_valid_o/out_stall_i | fcs_pkg::span_t span
//
// a command passes a set-up state, then one ring test per step with its spans,
// then a flush state that releases the last span; the sequencer steps the one
// span unit once a cycle unless the output stalls.
// radius zero leaves the block ready in the next cycle with no spans.
// reset clears the sequencer and the held and output valid flags.
// a stalled output with a span held keeps the sequencer in its span or flush state, unless the span is empty.
`default_nettype none

module filled_circle_span_generator_core #(
  parameter int unsigned MAX_RADIUS = 15
) (
  input  var logic           clk_i,
  input  var logic           rst_ni,
  input  var logic           in_valid_i,
  output logic               in_stall_o,
  input  var fcs_pkg::cmd_t  in_data_i,
  output logic               out_valid_o,
  input  var logic           out_stall_i,
  output fcs_pkg::span_t     out_data_o
);

  logic           busy;
  logic           adv;
  fcs_pkg::cmd_t  cmd;
  fcs_pkg::ctrl_t ctrl;
  fcs_pkg::span_t cand;

  assign in_stall_o = busy;

  // sequencer
  fcs_ctrl #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_valid_i),
    .cmd_i       (in_data_i),
    .adv_i       (adv),
    .busy_o      (busy),
    .cmd_o       (cmd),
    .ctrl_o      (ctrl)
  );

  // span arithmetic
  fcs_span_unit u_span (
    .cmd_i  (cmd),
    .ctrl_i (ctrl),
    .span_o (cand)
  );

  // hold and output registers
  fcs_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cand_i      (cand),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a zero-radius command leaves the block ready
  a_zero_radius_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.radius == '0)) |=> !in_stall_o)
    else $error("zero-radius command made the block busy");

  // any other command makes the block busy
  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.radius != '0)) |=> in_stall_o)
    else $error("accepted command did not start the sequencer");

  // no empty span leaves the block, and every length is even
  a_span_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.span_length != '0) && !out_data_o.span_length[0]))
    else $error("span length zero or odd");

endmodule

`default_nettype wire
